// File: hw/rtl/vfab_pkg.sv
// ----------------------------------------------------------------------------
// vfab_pkg
// Types and constants shared by the vertex-to-face adjacency builder.
// ----------------------------------------------------------------------------
package vfab_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int MAX_FACES     = 4096;
  localparam int MAX_FACE_SIZE = 16;
  localparam int MAX_VALENCE   = 16;

  localparam int CMD_W   = 2;
  localparam int VTX_W   = 10;
  localparam int FACE_W  = 12;
  localparam int CNT_W   = 13;
  localparam int LEN_W   = 5;
  localparam int STAT_W  = 2;
  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int SLOT_W  = $clog2(MAX_VALENCE);
  localparam int FB_W    = $clog2(MAX_FACE_SIZE);
  localparam int PAIR_W  = 2 * VTX_W;
  localparam int ENTRY_W = FACE_W + PAIR_W;
  localparam int LM_W    = LEN_W + 1;
  localparam int CM_AW   = VIDX_W + SLOT_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_VALID = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic              take;
    logic              clr_wr;
    logic [VIDX_W-1:0] clr_addr;
    logic              walk_rd;
    logic              walk_wr;
    logic              walk_done;
    logic              q_cap;
    logic              q_rd;
    logic [SLOT_W-1:0] q_idx;
    logic              q_load;
    logic              q_empty;
    logic              q_last;
  } vfab_ctl_t;

  typedef struct packed {
    logic             close_go;
    logic [LEN_W-1:0] fill;
    logic [LEN_W-1:0] q_len;
    logic             q_none;
    logic             out_free;
  } vfab_sts_t;

endpackage

// File: hw/rtl/vfab_if.sv
// ----------------------------------------------------------------------------
// vfab_if
// Valid/ready channels for command beats and query result beats.
// ----------------------------------------------------------------------------
interface vfab_in_if;
  logic                         valid;
  logic                         ready;
  logic [vfab_pkg::CMD_W-1:0]   cmd;
  logic [vfab_pkg::VTX_W-1:0]   vertex;
  logic                         face_end;

  modport source (output valid, cmd, vertex, face_end, input ready);
  modport sink   (input valid, cmd, vertex, face_end, output ready);
endinterface

interface vfab_out_if;
  logic                         valid;
  logic                         ready;
  logic [vfab_pkg::FACE_W-1:0]  face_id;
  logic [vfab_pkg::VTX_W-1:0]   prev_vertex;
  logic [vfab_pkg::VTX_W-1:0]   next_vertex;
  logic [vfab_pkg::LEN_W-1:0]   neighbor_count;
  logic [vfab_pkg::STAT_W-1:0]  status;
  logic                         load_error;
  logic [vfab_pkg::CNT_W-1:0]   face_total;
  logic [vfab_pkg::LEN_W-1:0]   largest_face;
  logic                         last;

  modport source (output valid, face_id, prev_vertex, next_vertex, neighbor_count, status,
                  load_error, face_total, largest_face, last, input ready);
  modport sink   (input valid, face_id, prev_vertex, next_vertex, neighbor_count, status,
                  load_error, face_total, largest_face, last, output ready);
endinterface

// File: hw/rtl/vfab_datapath.sv
// ----------------------------------------------------------------------------
// vfab_datapath
// Face buffer, list length and corner list memories, counters, result register.
// ----------------------------------------------------------------------------
module vfab_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vfab_pkg::vfab_ctl_t         ctl,
  input  logic [vfab_pkg::CMD_W-1:0]  in_cmd,
  input  logic [vfab_pkg::VTX_W-1:0]  in_vertex,
  input  logic                        in_face_end,
  input  logic                        out_ready,
  output vfab_pkg::vfab_sts_t         sts,
  output logic                        out_valid,
  output logic [vfab_pkg::FACE_W-1:0] out_face_id,
  output logic [vfab_pkg::VTX_W-1:0]  out_prev_vertex,
  output logic [vfab_pkg::VTX_W-1:0]  out_next_vertex,
  output logic [vfab_pkg::LEN_W-1:0]  out_neighbor_count,
  output logic [vfab_pkg::STAT_W-1:0] out_status,
  output logic                        out_load_error,
  output logic [vfab_pkg::CNT_W-1:0]  out_face_total,
  output logic [vfab_pkg::LEN_W-1:0]  out_largest_face,
  output logic                        out_last
);
  import vfab_pkg::*;

  logic [LM_W-1:0]    len_mem    [MAX_VERTICES];
  logic [ENTRY_W-1:0] corner_mem [MAX_VERTICES * MAX_VALENCE];

  logic [VTX_W-1:0]  fb_v_r    [MAX_FACE_SIZE];
  logic [PAIR_W-1:0] fb_pn_r   [MAX_FACE_SIZE];
  logic              fb_done_r [MAX_FACE_SIZE];

  logic [LEN_W-1:0]  fill_r, fill_after;
  logic [CNT_W-1:0]  fc_r;
  logic [LEN_W-1:0]  max_r;
  logic              err_r;
  logic [VTX_W-1:0]  last_v_r, prev_r;
  logic [PAIR_W-1:0] pair_r, pair;
  logic [LM_W-1:0]   lm_rd_r;
  logic [ENTRY_W-1:0] cm_rd_r;
  logic [VTX_W-1:0]  qv_r;
  logic              qv_oob_r;
  logic [LEN_W-1:0]  q_len_r;
  logic              q_ovf_r;
  logic              out_valid_r;

  logic              store_ok, in_oob;
  logic [VTX_W-1:0]  head, nxt;
  logic [VIDX_W-1:0] lm_raddr, lm_waddr;
  logic [LM_W-1:0]   lm_wdata;
  logic              lm_re, lm_we;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_ovf, room;
  logic              is_load, is_clear, is_query;

  assign in_oob     = 32'(in_vertex) >= MAX_VERTICES;
  assign store_ok   = !in_oob && (fill_r < LEN_W'(MAX_FACE_SIZE));
  assign fill_after = fill_r + LEN_W'(store_ok);
  assign is_load    = ctl.take && (in_cmd == CMD_LOAD);
  assign is_clear   = ctl.take && (in_cmd == CMD_CLEAR);
  assign is_query   = ctl.take && (in_cmd == CMD_QUERY);

  assign head    = fb_v_r[0];
  assign nxt     = (fill_r == LEN_W'(1)) ? fb_v_r[0] : fb_v_r[1];
  assign cur_len = lm_rd_r[LEN_W-1:0];
  assign cur_ovf = lm_rd_r[LM_W-1];
  assign room    = cur_len < LEN_W'(MAX_VALENCE);

  // repeated vertex takes the neighbors of its earliest processed copy
  always_comb begin
    pair = {prev_r, nxt};
    for (int i = MAX_FACE_SIZE - 1; i >= 1; i--) begin
      if (fb_done_r[i] && (LEN_W'(i) < fill_r) && (fb_v_r[i] == head)) pair = fb_pn_r[i];
    end
  end

  assign sts.close_go = (in_cmd == CMD_LOAD) && in_face_end && (fill_after != '0) &&
                        (fc_r < CNT_W'(MAX_FACES));
  assign sts.fill     = fill_r;
  assign sts.q_len    = q_len_r;
  assign sts.q_none   = qv_oob_r || (cur_len == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign lm_re    = ctl.walk_rd || is_query;
  assign lm_raddr = ctl.walk_rd ? head[VIDX_W-1:0] : in_vertex[VIDX_W-1:0];
  assign lm_we    = ctl.clr_wr || ctl.walk_wr;
  assign lm_waddr = ctl.clr_wr ? ctl.clr_addr : head[VIDX_W-1:0];
  assign lm_wdata = ctl.clr_wr ? '0 : (room ? {cur_ovf, cur_len + LEN_W'(1)} : {1'b1, cur_len});

  always_ff @(posedge clk) begin
    if (lm_we) len_mem[lm_waddr] <= lm_wdata;
    if (lm_re) lm_rd_r <= len_mem[lm_raddr];
    if (ctl.walk_wr && room)
      corner_mem[{head[VIDX_W-1:0], cur_len[SLOT_W-1:0]}] <= {fc_r[FACE_W-1:0], pair_r};
    if (ctl.q_rd) cm_rd_r <= corner_mem[{qv_r[VIDX_W-1:0], ctl.q_idx}];
  end

  // face buffer, walk and query registers
  always_ff @(posedge clk) begin
    if (is_load && store_ok) begin
      fb_v_r[fill_r[FB_W-1:0]]    <= in_vertex;
      fb_done_r[fill_r[FB_W-1:0]] <= 1'b0;
      last_v_r                    <= in_vertex;
    end
    if (is_load && sts.close_go) prev_r <= store_ok ? in_vertex : last_v_r;
    if (ctl.walk_rd) pair_r <= pair;
    if (ctl.walk_wr) begin
      prev_r <= head;
      for (int i = 0; i < MAX_FACE_SIZE; i++) begin
        if (LEN_W'(i) + LEN_W'(1) < fill_r) begin
          fb_v_r[i]    <= fb_v_r[i+1 < MAX_FACE_SIZE ? i+1 : i];
          fb_pn_r[i]   <= fb_pn_r[i+1 < MAX_FACE_SIZE ? i+1 : i];
          fb_done_r[i] <= fb_done_r[i+1 < MAX_FACE_SIZE ? i+1 : i];
        end else if (LEN_W'(i) + LEN_W'(1) == fill_r) begin
          fb_v_r[i]    <= head;
          fb_pn_r[i]   <= pair_r;
          fb_done_r[i] <= 1'b1;
        end
      end
    end
    if (is_query) begin
      qv_r     <= in_vertex;
      qv_oob_r <= in_oob;
    end
    if (ctl.q_cap) begin
      q_len_r <= cur_len;
      q_ovf_r <= cur_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      fc_r   <= '0;
      max_r  <= '0;
      err_r  <= 1'b0;
    end else if (is_clear) begin
      fill_r <= '0;
      fc_r   <= '0;
      max_r  <= '0;
      err_r  <= 1'b0;
    end else if (is_load) begin
      if (!store_ok) err_r <= 1'b1;
      if (in_face_end && !sts.close_go) begin
        fill_r <= '0;
        if (fill_after != '0) err_r <= 1'b1;
      end else begin
        fill_r <= fill_after;
      end
    end else if (ctl.walk_done) begin
      fill_r <= '0;
      fc_r   <= fc_r + CNT_W'(1);
      if (fill_r > max_r) max_r <= fill_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.q_load || ctl.q_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.q_load || ctl.q_empty) begin
      out_load_error   <= err_r;
      out_face_total   <= fc_r;
      out_largest_face <= max_r;
    end
    if (ctl.q_load) begin
      out_face_id        <= cm_rd_r[ENTRY_W-1 -: FACE_W];
      out_prev_vertex    <= cm_rd_r[PAIR_W-1 -: VTX_W];
      out_next_vertex    <= cm_rd_r[VTX_W-1:0];
      out_neighbor_count <= q_len_r;
      out_status         <= q_ovf_r ? ST_OVF : ST_VALID;
      out_last           <= ctl.q_last;
    end else if (ctl.q_empty) begin
      out_face_id        <= '0;
      out_prev_vertex    <= '0;
      out_next_vertex    <= '0;
      out_neighbor_count <= '0;
      out_status         <= ST_EMPTY;
      out_last           <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/vfab_controller.sv
// ----------------------------------------------------------------------------
// vfab_controller
// Sequencer for table clearing, face close walks and query readout.
// ----------------------------------------------------------------------------
module vfab_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [vfab_pkg::CMD_W-1:0] in_cmd,
  output logic                       in_ready,
  input  vfab_pkg::vfab_sts_t        sts,
  output vfab_pkg::vfab_ctl_t        ctl
);
  import vfab_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WWR  = 3'd3;
  localparam logic [2:0] S_QLEN = 3'd4;
  localparam logic [2:0] S_QRD  = 3'd5;
  localparam logic [2:0] S_QOUT = 3'd6;
  localparam logic [2:0] S_QEMP = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [VIDX_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [FB_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0] qi_r, qi_nxt;
  logic              q_last;

  assign q_last = (LEN_W'({1'b0, qi_r}) + LEN_W'(1)) == sts.q_len;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    k_nxt        = k_r;
    qi_nxt       = qi_r;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.clr_addr = clr_addr_r;
    ctl.q_idx    = qi_r;
    unique case (state_r)
      S_CLR: begin
        ctl.clr_wr   = 1'b1;
        clr_addr_nxt = clr_addr_r + VIDX_W'(1);
        if (clr_addr_r == VIDX_W'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take = 1'b1;
          case (in_cmd)
            CMD_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLR;
            end
            CMD_LOAD: begin
              if (sts.close_go) begin
                k_nxt     = '0;
                state_nxt = S_WRD;
              end
            end
            CMD_QUERY: state_nxt = S_QLEN;
            default: ;
          endcase
        end
      end
      S_WRD: begin
        ctl.walk_rd = 1'b1;
        state_nxt   = S_WWR;
      end
      S_WWR: begin
        ctl.walk_wr = 1'b1;
        if ((LEN_W'({1'b0, k_r}) + LEN_W'(1)) == sts.fill) begin
          ctl.walk_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = k_r + FB_W'(1);
          state_nxt = S_WRD;
        end
      end
      S_QLEN: begin
        ctl.q_cap = 1'b1;
        qi_nxt    = '0;
        state_nxt = sts.q_none ? S_QEMP : S_QRD;
      end
      S_QRD: begin
        ctl.q_rd  = 1'b1;
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (sts.out_free) begin
          ctl.q_load = 1'b1;
          ctl.q_last = q_last;
          if (q_last) begin
            state_nxt = S_IDLE;
          end else begin
            qi_nxt    = qi_r + SLOT_W'(1);
            state_nxt = S_QRD;
          end
        end
      end
      S_QEMP: begin
        if (sts.out_free) begin
          ctl.q_empty = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      k_r        <= '0;
      qi_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      k_r        <= k_nxt;
      qi_r       <= qi_nxt;
    end
  end

endmodule

// File: hw/rtl/vertex_face_adjacency_builder.sv
// ----------------------------------------------------------------------------
// vertex_face_adjacency_builder
// Builds per-vertex face lists from a streamed polygon mesh and answers queries.
// ----------------------------------------------------------------------------
// in_ch carries command beats: clear, load one corner (face_end closes the
// face) or query a vertex. out_ch carries query result beats, last marks the
// final one. Clear and load give no result; a query gives 1 to 16 beats.
// Closing a face walks its corners, one read and one write of the list
// length memory per corner. A query reads the list length, then reads each
// entry from the corner list memory in turn.
// After reset and after each clear, a pass zeroes the list length memory,
// one vertex per cycle, and in_ch.ready stays low meanwhile.
// The corner list memory holds no reset value.
// A result waits in the output register while out_ch.ready is low; the next
// command beat may be taken meanwhile, and query readout stalls until the
// output register frees up.
// ----------------------------------------------------------------------------
module vertex_face_adjacency_builder (
  input  logic       clk,
  input  logic       rst_n,
  vfab_in_if.sink    in_ch,
  vfab_out_if.source out_ch
);
  import vfab_pkg::*;

  vfab_ctl_t ctl;
  vfab_sts_t sts;

  vfab_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  vfab_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .in_cmd             (in_ch.cmd),
    .in_vertex          (in_ch.vertex),
    .in_face_end        (in_ch.face_end),
    .out_ready          (out_ch.ready),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_face_id        (out_ch.face_id),
    .out_prev_vertex    (out_ch.prev_vertex),
    .out_next_vertex    (out_ch.next_vertex),
    .out_neighbor_count (out_ch.neighbor_count),
    .out_status         (out_ch.status),
    .out_load_error     (out_ch.load_error),
    .out_face_total     (out_ch.face_total),
    .out_largest_face   (out_ch.largest_face),
    .out_last           (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk_wr |-> $past(ctl.walk_rd))
    else $error("list write without preceding length read");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.q_load || ctl.q_empty) |-> sts.out_free)
    else $error("result loaded over a pending beat");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.take, ctl.clr_wr, ctl.walk_rd, ctl.walk_wr, ctl.q_rd, ctl.q_load}))
    else $error("overlapping datapath operations");

  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> (in_ch.ready && !ctl.clr_wr))
    else $error("beat taken while busy");
`endif

endmodule
